// ===== rtl/nmea_gga_pkg.sv =====
// Shared types, constants and header table for the GGA field extractor.
package nmea_gga_pkg;

    localparam int MAX_SENTENCE    = 128;
    localparam int FIELD_MAX_CHARS = 11;
    localparam int NUM_FIELDS      = 9;
    localparam int HDR_LEN         = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] K_CHAR = 2'd0;
    localparam logic [1:0] K_FEND = 2'd1;
    localparam logic [1:0] K_SEND = 2'd2;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] field_number;
        logic [3:0] char_position;
        logic [7:0] char_value;
    } result_t;

    // Work left by one byte: an optional field result, then an optional sentence end.
    typedef struct packed {
        logic    has_first;
        result_t first;
        logic    has_send;
        logic    send_ok;
    } action_t;

    function automatic logic [7:0] header_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h47; // G
            3'd1:    c = 8'h50; // P
            3'd2:    c = 8'h47; // G
            3'd3:    c = 8'h47; // G
            3'd4:    c = 8'h41; // A
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/nmea_gga_front.sv =====
// Front end: sentence parser that turns each byte into a queued action.
module nmea_gga_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            rx_byte,
    input  logic                  q_full,
    output logic                  q_push,
    output nmea_gga_pkg::action_t q_data
);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_AFTER  = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    localparam logic [7:0] LEN_LIMIT  = 8'(nmea_gga_pkg::MAX_SENTENCE - 1);
    localparam logic [3:0] FIELD_LIM  = 4'(nmea_gga_pkg::NUM_FIELDS);
    localparam logic [3:0] CHAR_LIM   = 4'(nmea_gga_pkg::FIELD_MAX_CHARS);
    localparam logic [2:0] HDR_LAST   = 3'(nmea_gga_pkg::HDR_LEN - 1);
    localparam logic [2:0] HDR_END    = 3'(nmea_gga_pkg::HDR_LEN);

    logic [1:0] phase_reg,  phase_next;
    logic [2:0] hcount_reg, hcount_next;
    logic [3:0] field_reg,  field_next;
    logic [3:0] chars_reg,  chars_next;
    logic [7:0] len_reg,    len_next;
    logic       good_reg,   good_next;

    logic                  accept;
    logic                  eol;
    nmea_gga_pkg::action_t act;

    assign accept = push && !q_full;
    assign eol    = (rx_byte == nmea_gga_pkg::CH_CR) || (rx_byte == nmea_gga_pkg::CH_LF);

    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        field_next  = field_reg;
        chars_next  = chars_reg;
        len_next    = len_reg;
        good_next   = good_reg;
        act         = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (hcount_reg < HDR_END && rx_byte == nmea_gga_pkg::header_char(hcount_reg))
                begin
                    hcount_next = hcount_reg + 3'd1;
                    len_next    = len_reg + 8'd1;
                    if (hcount_reg == HDR_LAST)
                        phase_next = PH_AFTER;
                end
                else
                begin
                    phase_next  = (rx_byte == nmea_gga_pkg::CH_DOLLAR) ? PH_HEADER : PH_HUNT;
                    hcount_next = '0;
                    field_next  = '0;
                    chars_next  = '0;
                    len_next    = (rx_byte == nmea_gga_pkg::CH_DOLLAR) ? 8'd1 : 8'd0;
                    good_next   = 1'b0;
                end
            end
            PH_AFTER:
            begin
                if (eol)
                begin
                    act.has_send = 1'b1;
                    act.send_ok  = 1'b1;
                end
                else
                begin
                    len_next   = len_reg + 8'd1;
                    chars_next = '0;
                    good_next  = (rx_byte == nmea_gga_pkg::CH_COMMA) ||
                                 (rx_byte == nmea_gga_pkg::CH_NUL);
                    // a zero byte straight after the header shuts off field extraction
                    field_next = (rx_byte == nmea_gga_pkg::CH_NUL) ? FIELD_LIM : 4'd0;
                    phase_next = PH_BODY;
                    if (len_next >= LEN_LIMIT)
                    begin
                        act.has_send = 1'b1;
                        act.send_ok  = good_next;
                    end
                end
            end
            PH_BODY:
            begin
                if (eol)
                begin
                    act.has_send = 1'b1;
                    act.send_ok  = good_reg;
                end
                else
                begin
                    len_next = len_reg + 8'd1;
                    if (good_reg && field_reg < FIELD_LIM)
                    begin
                        if (rx_byte == nmea_gga_pkg::CH_COMMA)
                        begin
                            act.has_first          = 1'b1;
                            act.first.kind         = nmea_gga_pkg::K_FEND;
                            act.first.field_number = field_reg;
                            field_next             = field_reg + 4'd1;
                            chars_next             = '0;
                        end
                        else if (rx_byte == nmea_gga_pkg::CH_NUL)
                        begin
                            field_next = FIELD_LIM;
                        end
                        else if (chars_reg < CHAR_LIM)
                        begin
                            act.has_first           = 1'b1;
                            act.first.kind          = nmea_gga_pkg::K_CHAR;
                            act.first.field_number  = field_reg;
                            act.first.char_position = chars_reg;
                            act.first.char_value    = rx_byte;
                            chars_next              = chars_reg + 4'd1;
                        end
                    end
                    if (len_next >= LEN_LIMIT)
                    begin
                        act.has_send = 1'b1;
                        act.send_ok  = good_reg;
                    end
                end
            end
            default:
            begin
                phase_next  = (rx_byte == nmea_gga_pkg::CH_DOLLAR) ? PH_HEADER : PH_HUNT;
                hcount_next = '0;
                field_next  = '0;
                chars_next  = '0;
                len_next    = (rx_byte == nmea_gga_pkg::CH_DOLLAR) ? 8'd1 : 8'd0;
                good_next   = 1'b0;
            end
        endcase

        // any sentence end returns to hunting with a clean slate
        if (act.has_send)
        begin
            phase_next  = PH_HUNT;
            hcount_next = '0;
            field_next  = '0;
            chars_next  = '0;
            len_next    = '0;
            good_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            hcount_reg <= '0;
            field_reg  <= '0;
            chars_reg  <= '0;
            len_reg    <= '0;
            good_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            hcount_reg <= hcount_next;
            field_reg  <= field_next;
            chars_reg  <= chars_next;
            len_reg    <= len_next;
            good_reg   <= good_next;
        end
    end

    assign q_push = accept && (act.has_first || act.has_send);
    assign q_data = act;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg < LEN_LIMIT)
        else $error("sentence length reached the buffer limit without a sentence end");

    a_hunt_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HUNT |-> (len_reg == 8'd0 && !good_reg && hcount_reg == 3'd0))
        else $error("hunting with stale sentence state");

    a_send_clears: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && q_data.has_send |=> phase_reg == PH_HUNT)
        else $error("sentence end did not return to hunting");

endmodule

// ===== rtl/nmea_gga_queue.sv =====
// Short action queue between the parser and the result sequencer.
module nmea_gga_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  nmea_gga_pkg::action_t wr_data,
    input  logic                  rd_en,
    output nmea_gga_pkg::action_t rd_data,
    output logic                  q_full,
    output logic                  q_empty
);

    localparam logic [nmea_gga_pkg::QUEUE_AW-1:0] PTR_ONE = 1;
    localparam logic [nmea_gga_pkg::QUEUE_CW-1:0] CNT_ONE = 1;
    localparam logic [nmea_gga_pkg::QUEUE_CW-1:0] CNT_MAX =
        nmea_gga_pkg::QUEUE_CW'(nmea_gga_pkg::QUEUE_DEPTH);

    nmea_gga_pkg::action_t slot_reg [nmea_gga_pkg::QUEUE_DEPTH];

    logic [nmea_gga_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [nmea_gga_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [nmea_gga_pkg::QUEUE_CW-1:0] count_reg,  count_next;

    logic do_wr;
    logic do_rd;

    assign q_full  = (count_reg == CNT_MAX);
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + PTR_ONE : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_ONE;
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_ONE;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/nmea_gga_back.sv =====
// Back end: expands each queued action into one or two result transfers.
module nmea_gga_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nmea_gga_pkg::action_t head,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic [1:0]            kind,
    output logic [3:0]            field_number,
    output logic [3:0]            char_position,
    output logic [7:0]            char_value,
    output logic                  sentence_ok,
    output logic                  is_last
);

    logic sub_reg, sub_next;   // set once the field result of a two-result action is gone
    logic show_first;
    logic take;

    assign empty      = q_empty;
    assign show_first = head.has_first && !sub_reg;
    assign take       = pop && !q_empty;

    always_comb
    begin
        if (show_first)
        begin
            kind          = head.first.kind;
            field_number  = head.first.field_number;
            char_position = head.first.char_position;
            char_value    = head.first.char_value;
            sentence_ok   = 1'b0;
            is_last       = !head.has_send;
        end
        else
        begin
            kind          = nmea_gga_pkg::K_SEND;
            field_number  = '0;
            char_position = '0;
            char_value    = '0;
            sentence_ok   = head.send_ok;
            is_last       = 1'b1;
        end
    end

    always_comb
    begin
        sub_next = sub_reg;
        if (take)
            sub_next = show_first && head.has_send;
    end

    assign q_pop = take && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sub_reg <= 1'b0;
        else
            sub_reg <= sub_next;
    end

    a_sub_valid: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (!q_empty && head.has_first && head.has_send))
        else $error("second half pending without a two-result action at the head");

    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (head.has_first || head.has_send))
        else $error("queued action carries no result");

    a_split_follow: assert property (@(posedge clk) disable iff (!rst_n)
        take && !is_last |=> (sub_reg && kind == nmea_gga_pkg::K_SEND))
        else $error("sentence end did not follow the field result");

endmodule

// ===== rtl/nmea_gga_field_extractor_core.sv =====
// Top level: NMEA GGA field extractor, parser front, action queue, result back.
//
//   channel   direction  handshake            payload
//   input     in         push / full          rx_byte
//   result    out        pop / empty          kind, field_number, char_position,
//                                             char_value, sentence_ok, is_last
//
// One byte a cycle is taken while the action queue (4 entries) has room.
// A byte that yields both a field result and a sentence end holds the queue
// head for two result transfers; results leave one per cycle while pop is high.
// An accepted byte's action is registered in the queue; results leave from its head.
// Reset (rst_n low, asynchronous) empties the queue and returns to hunting for '$'.
// A stalled result side fills the queue and then raises full.
module nmea_gga_field_extractor_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] kind,
    output logic [3:0] field_number,
    output logic [3:0] char_position,
    output logic [7:0] char_value,
    output logic       sentence_ok,
    output logic       is_last
);

    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    nmea_gga_pkg::action_t q_wdata;
    nmea_gga_pkg::action_t q_rdata;

    assign full = q_full;

    nmea_gga_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rx_byte (rx_byte),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_wdata)
    );

    nmea_gga_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    nmea_gga_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_rdata),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .kind          (kind),
        .field_number  (field_number),
        .char_position (char_position),
        .char_value    (char_value),
        .sentence_ok   (sentence_ok),
        .is_last       (is_last)
    );

endmodule
